// ----- rtl/core/sle_pkg.sv -----
// sle_pkg: shared constants, codes and types of the sequential list engine
// no dependencies; imported by every module under rtl/core
package sle_pkg;

   localparam int DEPTH   = 256;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = IDX_W + 1;
   localparam int ACT_W   = 3;
   localparam int POS_W   = 9;
   localparam int DATA_W  = 32;
   localparam int STAT_W  = 2;
   localparam int FOUND_W = 8;
   localparam int CAP_W   = 9;

   localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DEL_POS = 3'd1;
   localparam logic [ACT_W-1:0] ACT_DEL_VAL = 3'd2;
   localparam logic [ACT_W-1:0] ACT_FIND    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_READ    = 3'd4;
   localparam logic [ACT_W-1:0] ACT_REPLACE = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] new_value;
   } sle_request_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic [FOUND_W-1:0]       found_index;
      logic signed [DATA_W-1:0] read_data;
      logic [CNT_W-1:0]         removed_count;
      logic [CNT_W-1:0]         entry_count;
   } sle_result_type;

endpackage

// ----- rtl/core/sle_ram.sv -----
// sle_ram: list entry storage, one write port and one registered read port
// uses sle_pkg for depth and word width
module sle_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [sle_pkg::IDX_W-1:0]    wr_addr,
   input  logic [sle_pkg::DATA_W-1:0]   wr_data,
   input  logic                         rd_en,
   input  logic [sle_pkg::IDX_W-1:0]    rd_addr,
   output logic [sle_pkg::DATA_W-1:0]   rd_data
);
   import sle_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sle_engine.sv -----
// sle_engine: sequencer that walks the list one entry per cycle with one compare unit
// uses sle_pkg and instantiates sle_ram
module sle_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  sle_pkg::sle_request_type    req,
   input  logic [sle_pkg::CNT_W-1:0]   capacity,
   output logic                        idle,
   output logic                        res_valid,
   input  logic                        res_take,
   output sle_pkg::sle_result_type     res
);
   import sle_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [ACT_W-1:0]   act_ff, act_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [DATA_W-1:0]  val_ff, val_in;
   logic [DATA_W-1:0]  nval_ff, nval_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic [IDX_W-1:0]   rd_ff, rd_in;
   logic               down_ff, down_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   src_ff, src_in;
   logic [CNT_W-1:0]   keep_ff, keep_in;
   logic               hit_ff, hit_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [FOUND_W-1:0] found_ff, found_in;
   logic [DATA_W-1:0]  rdata_ff, rdata_in;
   logic [CNT_W-1:0]   removed_ff, removed_in;

   logic               wr_en, rd_en, match;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [DATA_W-1:0]  wr_data, ram_rdata;

   sle_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // shared compare unit
   assign match = (ram_rdata == val_ff);

   always_comb begin
      state_in   = state_ff;
      act_in     = act_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      nval_in    = nval_ff;
      count_in   = count_ff;
      left_in    = left_ff;
      rd_in      = rd_ff;
      down_in    = down_ff;
      pend_in    = 1'b0;
      src_in     = src_ff;
      keep_in    = keep_ff;
      hit_in     = hit_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      rdata_in   = rdata_ff;
      removed_in = removed_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = rd_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in     = req.action;
               pos_in     = req.position[IDX_W-1:0];
               val_in     = req.value;
               nval_in    = req.new_value;
               status_in  = STAT_OK;
               found_in   = '0;
               rdata_in   = '0;
               removed_in = '0;
               keep_in    = '0;
               hit_in     = 1'b0;
               down_in    = 1'b0;
               rd_in      = '0;
               left_in    = '0;
               state_in   = S_RUN;
               case (req.action)
                  ACT_INSERT: begin
                     if (count_ff >= capacity) begin
                        status_in = STAT_FULL;
                        state_in  = S_DONE;
                     end else if (req.position > POS_W'(count_ff)) begin
                        status_in = STAT_BAD_POS;
                        state_in  = S_DONE;
                     end else begin
                        left_in = count_ff - CNT_W'(req.position);
                        rd_in   = IDX_W'(count_ff - CNT_W'(1));
                        down_in = 1'b1;
                     end
                  end
                  ACT_DEL_POS: begin
                     if (req.position >= POS_W'(count_ff)) begin
                        status_in = STAT_BAD_POS;
                        state_in  = S_DONE;
                     end else begin
                        left_in = count_ff - CNT_W'(req.position) - CNT_W'(1);
                        rd_in   = IDX_W'(req.position + POS_W'(1));
                     end
                  end
                  ACT_DEL_VAL, ACT_REPLACE: begin
                     left_in = count_ff;
                  end
                  ACT_FIND: begin
                     left_in   = count_ff;
                     status_in = STAT_NOT_FOUND;
                  end
                  ACT_READ: begin
                     left_in = CNT_W'(1);
                     if (req.position >= POS_W'(count_ff)) begin
                        status_in = STAT_BAD_POS;
                     end else begin
                        rd_in = req.position[IDX_W-1:0];
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_RUN: begin
            // read side: one entry per cycle
            if (left_ff != '0) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               src_in  = rd_ff;
               left_in = left_ff - CNT_W'(1);
               rd_in   = down_ff ? rd_ff - IDX_W'(1) : rd_ff + IDX_W'(1);
            end

            // data side: entry read in the previous cycle
            if (pend_ff) begin
               case (act_ff)
                  ACT_INSERT: begin
                     wr_en   = 1'b1;
                     wr_addr = src_ff + IDX_W'(1);
                     wr_data = ram_rdata;
                  end
                  ACT_DEL_POS: begin
                     wr_en   = 1'b1;
                     wr_addr = src_ff - IDX_W'(1);
                     wr_data = ram_rdata;
                  end
                  ACT_DEL_VAL: begin
                     if (!match) begin
                        wr_en   = 1'b1;
                        wr_addr = keep_ff[IDX_W-1:0];
                        wr_data = ram_rdata;
                        keep_in = keep_ff + CNT_W'(1);
                     end
                  end
                  ACT_FIND: begin
                     if (match && !hit_ff) begin
                        hit_in    = 1'b1;
                        status_in = STAT_OK;
                        found_in  = FOUND_W'(src_ff);
                        left_in   = '0;
                        pend_in   = 1'b0;
                     end
                  end
                  ACT_READ: begin
                     rdata_in = ram_rdata;
                  end
                  ACT_REPLACE: begin
                     if (match) begin
                        wr_en   = 1'b1;
                        wr_addr = src_ff;
                        wr_data = nval_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            // wrap up once the walk has drained
            if (left_ff == '0 && !pend_ff) begin
               state_in = S_DONE;
               case (act_ff)
                  ACT_INSERT: begin
                     wr_en    = 1'b1;
                     wr_addr  = pos_ff;
                     wr_data  = val_ff;
                     count_in = count_ff + CNT_W'(1);
                  end
                  ACT_DEL_POS: begin
                     count_in = count_ff - CNT_W'(1);
                  end
                  ACT_DEL_VAL: begin
                     removed_in = count_ff - keep_ff;
                     count_in   = keep_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      nval_ff    <= nval_in;
      left_ff    <= left_in;
      rd_ff      <= rd_in;
      down_ff    <= down_in;
      src_ff     <= src_in;
      keep_ff    <= keep_in;
      hit_ff     <= hit_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      rdata_ff   <= rdata_in;
      removed_ff <= removed_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      res.status        = status_ff;
      res.found_index   = found_ff;
      res.read_data     = rdata_ff;
      res.removed_count = removed_ff;
      res.entry_count   = count_ff;
   end

endmodule

// ----- rtl/core/sequential_list_engine_core.sv -----
// sequential_list_engine_core: top level with capacity register and response register
// uses sle_pkg and instantiates sle_engine
//
// A packed list of up to 256 signed 32-bit words held in a single-port-write,
// registered-read memory. One request is handled at a time and req_stall stays
// high while it runs. Checks that fail at once (list full, bad insert or delete
// position, unknown action) go straight to a response; a read fetches a single
// entry; insert, delete at position, delete value, find and replace walk the
// entries involved one per cycle through the memory read port. The response
// sits in an output register, so the next request is accepted while an earlier
// response is still stalled. The capacity register is clamped to 1..256 when used.
module sequential_list_engine_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sle_pkg::ACT_W-1:0]     req_action,
   input  logic [sle_pkg::POS_W-1:0]     req_position,
   input  logic signed [sle_pkg::DATA_W-1:0] req_value,
   input  logic signed [sle_pkg::DATA_W-1:0] req_new_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sle_pkg::STAT_W-1:0]    rsp_status,
   output logic [sle_pkg::FOUND_W-1:0]   rsp_found_index,
   output logic signed [sle_pkg::DATA_W-1:0] rsp_read_data,
   output logic [sle_pkg::CNT_W-1:0]     rsp_removed_count,
   output logic [sle_pkg::CNT_W-1:0]     rsp_entry_count,
   input  logic                          csr_wr_en,
   input  logic [sle_pkg::CAP_W-1:0]     csr_wr_data
);
   import sle_pkg::*;

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] cap_eff;
   logic             eng_idle, eng_res_valid, res_take, start;
   sle_request_type  eng_req;
   sle_result_type   eng_res;
   logic             rsp_valid_ff, rsp_valid_in;
   sle_result_type   rsp_ff, rsp_in;

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (CNT_W'(cap_ff) > CNT_W'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   assign req_stall = !eng_idle;
   assign start     = req_valid && eng_idle;

   always_comb begin
      eng_req.action    = req_action;
      eng_req.position  = req_position;
      eng_req.value     = req_value;
      eng_req.new_value = req_new_value;
   end

   sle_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (eng_req),
      .capacity  (cap_eff),
      .idle      (eng_idle),
      .res_valid (eng_res_valid),
      .res_take  (res_take),
      .res       (eng_res)
   );

   // response register frees the engine as soon as a result is parked
   assign res_take = eng_res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_found_index   = rsp_ff.found_index;
   assign rsp_read_data     = rsp_ff.read_data;
   assign rsp_removed_count = rsp_ff.removed_count;
   assign rsp_entry_count   = rsp_ff.entry_count;

endmodule
